// ----- rtl/scf_pkg.sv -----
// shared types, constants and tables for the spectral centroid and flatness block
package scf_pkg;

    localparam int BinCount = 64;
    localparam int PosW = $clog2(BinCount);
    localparam int EnergyW = 22;
    localparam int WeightW = 28;
    localparam int LogSumW = 24;
    localparam int LogCntW = 7;
    localparam logic [EnergyW-1:0] EnergyMax = '1;
    localparam logic [WeightW-1:0] WeightMax = '1;
    localparam logic [LogSumW-1:0] LogSumMax = '1;
    localparam logic [LogCntW-1:0] LogCntMax = '1;
    localparam logic [11:0] Ln2Q12 = 12'd2839;
    localparam logic [12:0] InvLn2Q12 = 13'd5909;
    localparam logic [15:0] LogFloor = 16'd65;
    localparam logic [15:0] CentroidSilence = 16'd32768;
    localparam logic [16:0] OneQ16 = 17'd65536;
    localparam int DivW = 40;

    localparam logic [1:0] RegAttack = 2'd0;
    localparam logic [1:0] RegDecay = 2'd1;
    localparam logic [1:0] RegFeature = 2'd2;

    typedef struct packed {
        logic [15:0] bin_energy;
        logic frame_end;
    } t_in_item;

    typedef struct packed {
        logic [15:0] centroid_out;
        logic [16:0] flatness_out;
        logic [16:0] energy_scale;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // latch input item, read store
        logic smooth;    // compute smoothed value
        logic accum;     // write store, add running terms
        logic prep;      // compute centroid and flatness valid flags
        logic div_start;
        logic sel_flat;  // 1: divider works on flatness operands
        logic flat_prep; // capture centroid, divider works on mean log operands
        logic track;     // update tracks and result register
        logic clear;     // clear running terms
    } t_cmd;

    typedef struct packed {
        logic last;
        logic div_busy;
    } t_sts;

    function automatic logic [11:0] lnt(input logic [4:0] k);
        logic [11:0] r;
        case (k)
            5'd0: r = 12'd0;    5'd1: r = 12'd126;  5'd2: r = 12'd248;
            5'd3: r = 12'd367;  5'd4: r = 12'd482;  5'd5: r = 12'd595;
            5'd6: r = 12'd704;  5'd7: r = 12'd810;  5'd8: r = 12'd914;
            5'd9: r = 12'd1015; 5'd10: r = 12'd1114; 5'd11: r = 12'd1210;
            5'd12: r = 12'd1304; 5'd13: r = 12'd1396; 5'd14: r = 12'd1486;
            5'd15: r = 12'd1575; 5'd16: r = 12'd1661; 5'd17: r = 12'd1745;
            5'd18: r = 12'd1828; 5'd19: r = 12'd1909; 5'd20: r = 12'd1989;
            5'd21: r = 12'd2067; 5'd22: r = 12'd2143; 5'd23: r = 12'd2218;
            5'd24: r = 12'd2292; 5'd25: r = 12'd2365; 5'd26: r = 12'd2436;
            5'd27: r = 12'd2506; 5'd28: r = 12'd2575; 5'd29: r = 12'd2642;
            5'd30: r = 12'd2709; 5'd31: r = 12'd2775;
            default: r = 12'd0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] expt(input logic [4:0] k);
        logic [16:0] r;
        case (k)
            5'd0: r = 17'd65536; 5'd1: r = 17'd64132; 5'd2: r = 17'd62757;
            5'd3: r = 17'd61413; 5'd4: r = 17'd60097; 5'd5: r = 17'd58809;
            5'd6: r = 17'd57549; 5'd7: r = 17'd56315; 5'd8: r = 17'd55109;
            5'd9: r = 17'd53928; 5'd10: r = 17'd52772; 5'd11: r = 17'd51641;
            5'd12: r = 17'd50535; 5'd13: r = 17'd49452; 5'd14: r = 17'd48392;
            5'd15: r = 17'd47355; 5'd16: r = 17'd46341; 5'd17: r = 17'd45348;
            5'd18: r = 17'd44376; 5'd19: r = 17'd43424; 5'd20: r = 17'd42495;
            5'd21: r = 17'd41584; 5'd22: r = 17'd40693; 5'd23: r = 17'd39821;
            5'd24: r = 17'd38968; 5'd25: r = 17'd38133; 5'd26: r = 17'd37316;
            5'd27: r = 17'd36516; 5'd28: r = 17'd35734; 5'd29: r = 17'd34968;
            5'd30: r = 17'd34219; 5'd31: r = 17'd33484;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // moving average step, truncating toward the old value
    function automatic logic [16:0] ema(input logic [16:0] s, input logic [16:0] t,
                                        input logic [15:0] a);
        logic [16:0] d;
        logic [32:0] p;
        d = (t > s) ? (t - s) : (s - t);
        p = d * a;
        return (t > s) ? (s + p[32:16]) : (s - p[32:16]);
    endfunction

endpackage

// ----- rtl/scf_div.sv -----
// restoring divider, one quotient bit per cycle
module scf_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [scf_pkg::DivW-1:0] i_num,
    input  logic [23:0]              i_den,
    output logic                     o_busy,
    output logic [scf_pkg::DivW-1:0] o_quo
);
    import scf_pkg::*;

    logic [DivW-1:0] r_quo;
    logic [24:0]     r_rem;
    logic [23:0]     r_den;
    logic [5:0]      r_cnt;
    logic            r_busy;
    logic [24:0]     w_trial;

    assign w_trial = {r_rem[23:0], r_quo[DivW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(DivW);
            r_quo  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= w_trial - {1'b0, r_den};
                r_quo <= {r_quo[DivW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[DivW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

// ----- rtl/scf_datapath.sv -----
// datapath: bin store, running terms, feature math and tracks
module scf_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scf_pkg::t_cmd     i_cmd,
    output scf_pkg::t_sts     o_sts,
    input  scf_pkg::t_in_item i_item,
    input  logic [15:0]       i_attack,
    input  logic [15:0]       i_decay,
    input  logic [15:0]       i_feature,
    output scf_pkg::t_out_item o_result
);
    import scf_pkg::*;

    logic [15:0] r_mem [BinCount];
    logic [BinCount-1:0] r_vld;
    logic [15:0] r_rd;
    logic [15:0] r_t;
    logic        r_last;
    logic [PosW-1:0] r_pos;
    logic [15:0] r_s;
    logic [EnergyW-1:0] r_energy;
    logic [WeightW-1:0] r_weight;
    logic [LogSumW-1:0] r_logsum;
    logic [LogCntW-1:0] r_logcnt;
    logic [15:0] r_ctrack;
    logic [16:0] r_ftrack;
    logic [15:0] r_centroid;
    logic [16:0] r_g;
    logic        r_flat_ok;
    logic        r_cen_ok;
    t_out_item   r_result;

    logic [16:0] w_s;
    logic [3:0]  w_p;
    logic [4:0]  w_k;
    logic [15:0] w_nlog;
    logic [WeightW:0] w_wsum;
    logic [EnergyW:0] w_esum;
    logic [LogSumW:0] w_lsum;
    logic [21:0] w_prod;
    logic [DivW-1:0] w_num;
    logic [23:0] w_den;
    logic        w_busy;
    logic [DivW-1:0] w_quo;
    logic [36:0] w_mu;
    logic [24:0] w_u;
    logic [16:0] w_cen;
    logic [16:0] w_flat;
    logic [EnergyW+1:0] w_es;

    // store read-modify-write, entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd <= r_vld[r_pos] ? r_mem[r_pos] : 16'd0;
        end
        if (i_cmd.accum) begin
            r_mem[r_pos] <= r_s;
        end
    end

    assign w_s = ema({1'b0, r_rd}, {1'b0, r_t}, (r_t > r_rd) ? i_attack : i_decay);

    always_comb begin
        w_p = 4'd6;
        for (int i = 7; i <= 15; i++) begin
            if (r_s[i]) w_p = 4'(i);
        end
    end
    assign w_k    = 5'(r_s >> (w_p - 4'd5));
    assign w_nlog = 16'(5'd16 - {1'b0, w_p}) * 16'(Ln2Q12) - 16'(lnt(w_k));
    assign w_prod = r_pos * r_s;
    assign w_esum = r_energy + r_s;
    assign w_wsum = r_weight + w_prod;
    assign w_lsum = r_logsum + w_nlog;

    // divider operands: centroid first, mean log second, flatness third
    always_comb begin
        if (i_cmd.sel_flat) begin
            w_num = DivW'({r_g, 16'd0}) << PosW;
            w_den = 24'(r_energy);
        end else if (i_cmd.flat_prep) begin
            w_num = DivW'(r_logsum);
            w_den = 24'(r_logcnt);
        end else begin
            w_num = DivW'({r_weight, 10'd0});
            w_den = 24'(r_energy);
        end
    end

    scf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_busy (w_busy),
        .o_quo  (w_quo)
    );

    assign w_mu = 37'(w_quo[23:0]) * InvLn2Q12;
    assign w_u  = w_mu[36:12];
    assign w_cen = r_cen_ok ? ((r_centroid == 16'hFFFF) ? 17'hFFFF : {1'b0, r_centroid})
                            : {1'b0, CentroidSilence};
    assign w_flat = !r_flat_ok ? 17'd0 :
                    ((|w_quo[DivW-1:17]) || (w_quo[16:0] > OneQ16)) ? OneQ16 : w_quo[16:0];
    assign w_es = {r_energy, 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_pos    <= '0;
            r_energy <= '0;
            r_weight <= '0;
            r_logsum <= '0;
            r_logcnt <= '0;
            r_ctrack <= '0;
            r_ftrack <= '0;
        end else begin
            if (i_cmd.load) begin
                r_t    <= i_item.bin_energy;
                r_last <= i_item.frame_end;
            end
            if (i_cmd.smooth) begin
                r_s <= w_s[15:0];
            end
            if (i_cmd.accum) begin
                r_vld[r_pos] <= 1'b1;
                r_energy <= w_esum[EnergyW] ? EnergyMax : w_esum[EnergyW-1:0];
                r_weight <= w_wsum[WeightW] ? WeightMax : w_wsum[WeightW-1:0];
                if (r_s > LogFloor) begin
                    r_logsum <= w_lsum[LogSumW] ? LogSumMax : w_lsum[LogSumW-1:0];
                    if (r_logcnt != LogCntMax) r_logcnt <= r_logcnt + 1'b1;
                end
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.prep) begin
                r_cen_ok  <= (r_energy * 7'd100) > 29'd65536;
                r_flat_ok <= (r_logcnt != '0) &&
                             ((r_energy * 10'd1000) > 32'(65536 * BinCount));
            end
            if (i_cmd.flat_prep) begin
                // divider holds centroid quotient here
                r_centroid <= (|w_quo[DivW-1:16]) ? 16'hFFFF : w_quo[15:0];
            end
            if (i_cmd.sel_flat) begin
                r_g <= (w_u[24:12] >= 13'd17) ? 17'd0 : (expt(w_u[11:7]) >> w_u[16:12]);
            end
            if (i_cmd.track) begin
                r_ctrack <= 16'(ema({1'b0, r_ctrack}, w_cen, i_feature));
                r_ftrack <= ema(r_ftrack, w_flat, i_feature);
            end
            if (i_cmd.clear) begin
                r_pos    <= '0;
                r_energy <= '0;
                r_weight <= '0;
                r_logsum <= '0;
                r_logcnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.track) begin
            r_result.centroid_out <= 16'(ema({1'b0, r_ctrack}, w_cen, i_feature));
            r_result.flatness_out <= ema(r_ftrack, w_flat, i_feature);
            r_result.energy_scale <= (w_es > 24'(OneQ16)) ? OneQ16 : w_es[16:0];
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.div_busy = w_busy;
    assign o_result       = r_result;

    a_clear_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> r_pos == '0 && r_energy == '0)
        else $error("running terms not cleared");
    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_logcnt) == LogCntMax && !$past(i_cmd.clear) |-> r_logcnt == LogCntMax)
        else $error("log count wrapped");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !w_busy)
        else $error("divider restarted while busy");
endmodule

// ----- rtl/scf_ctrl.sv -----
// controller state machine sequencing one bin item and the frame result
module scf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output scf_pkg::t_cmd o_cmd,
    input  scf_pkg::t_sts i_sts
);
    import scf_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SMOOTH= 12'b000000000010,
        S_ACCUM = 12'b000000000100,
        S_PREP  = 12'b000000001000,
        S_CDIV  = 12'b000000010000,
        S_CWAIT = 12'b000000100000,
        S_MWAIT = 12'b000001000000,
        S_GCALC = 12'b000010000000,
        S_FDIV  = 12'b000100000000,
        S_FWAIT = 12'b001000000000,
        S_TRACK = 12'b010000000000,
        S_CLEAR = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_in_acc;

    // input taken in idle, also while a result still waits
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SMOOTH;
                end
            end
            S_SMOOTH: begin
                o_cmd.smooth = 1'b1;
                n_state      = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_sts.last ? S_PREP : S_IDLE;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_CDIV;
            end
            S_CDIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_CWAIT;
            end
            S_CWAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.flat_prep = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_MWAIT;
                end
            end
            S_MWAIT: begin
                if (!i_sts.div_busy) n_state = S_GCALC;
            end
            S_GCALC: begin
                o_cmd.sel_flat = 1'b1;
                n_state        = S_FDIV;
            end
            S_FDIV: begin
                // g is registered now; start the final divide
                o_cmd.sel_flat  = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = S_FWAIT;
            end
            S_FWAIT: begin
                if (!i_sts.div_busy) n_state = S_TRACK;
            end
            S_TRACK: begin
                // previous result must be taken before the result register changes
                if (!r_out_valid) begin
                    o_cmd.track = 1'b1;
                    n_state     = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    a_no_load_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_state == S_CLEAR |-> 1'b0)
        else $error("new result while previous not taken");
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("result dropped");
endmodule

// ----- rtl/spectral_centroid_flatness.sv -----
// top level of the spectral centroid and flatness tracker
// ordinary bin item: load, smooth and accumulate steps
// frame end bin: result valid after three waits on the shared bit-serial divider
//   (centroid, mean log, flatness)
// input: a new bin item is taken only once the previous one is through; bins
//   keep flowing while a result waits, the next frame end stalls until it is taken
// reset: synchronous active low, clears state, running terms, tracks and the
//   per-entry written flags of the bin store, so unwritten entries read as zero
module spectral_centroid_flatness (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  scf_pkg::t_in_item     i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output scf_pkg::t_out_item    o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import scf_pkg::*;

    logic [15:0] r_attack;
    logic [15:0] r_decay;
    logic [15:0] r_feature;
    t_cmd        w_cmd;
    t_sts        w_sts;

    // configuration registers, word addressed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= 16'd35000;
            r_decay   <= 16'd7000;
            r_feature <= 16'd10500;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                RegAttack:  r_attack  <= pwdata[15:0];
                RegDecay:   r_decay   <= pwdata[15:0];
                RegFeature: r_feature <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            RegAttack:  prdata = {16'd0, r_attack};
            RegDecay:   prdata = {16'd0, r_decay};
            RegFeature: prdata = {16'd0, r_feature};
            default:    prdata = 32'd0;
        endcase
    end
    assign pready = 1'b1;

    scf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    scf_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_item   (i_in_item),
        .i_attack (r_attack),
        .i_decay  (r_decay),
        .i_feature(r_feature),
        .o_result (o_out_item)
    );
endmodule
